// ===== design/gamepad_report_normalizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Gamepad report normaliser assertion macros
// Shared forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_NORMALIZER_TOP_MACROS_SVH
`define GAMEPAD_REPORT_NORMALIZER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define GPRN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed delay, disabled in reset
`define GPRN_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== design/gprn_pkg.sv =====
// ----------------------------------------------------------------------------
// Gamepad report normaliser package
// Widths, reset values, register indexes and pipeline payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package gprn_pkg;

  localparam int MAG_W  = 15;
  localparam int QW     = 7;
  localparam int NUM_W  = MAG_W + QW;
  localparam int RAW_W  = 16;
  localparam int POS_W  = 8;

  localparam logic [MAG_W-1:0] THUMB_MAX = 15'h7FFF;
  localparam logic [POS_W-1:0] POS_MIN   = 8'h80;
  localparam logic [POS_W-1:0] POS_MAX   = 8'h7F;

  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [6:0]  DIG_TH_RST   = 7'd32;
  localparam logic [7:0]  TRIG_TH_RST  = 8'd30;

  localparam int DEF_QBITS_PER_STAGE = 2;

  typedef enum logic [1:0] {
    CFG_LEFT_DZ  = 2'd0,
    CFG_RIGHT_DZ = 2'd1,
    CFG_DIG_TH   = 2'd2,
    CFG_TRIG_TH  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             zero;
    logic             neg;
    logic [NUM_W-1:0] rem;
    logic [QW-1:0]    quo;
  } lane_t;

  typedef struct packed {
    logic [15:0] buttons;
    logic        lt_hit;
    logic        rt_hit;
  } side_t;

endpackage

`default_nettype wire

// ===== design/gamepad_report_normalizer_top.sv =====
// ----------------------------------------------------------------------------
// Gamepad report normaliser
// Each report is registered through the axis front end, the divider stages and
// the output stage, with QBITS_PER_STAGE (default two) quotient bits per stage.
// Throughput: one report per cycle; busy is high only while rst_n is low.
// Reset clears the valid chain and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_report_normalizer_top
  import gprn_pkg::*;
#(
  parameter int QBITS_PER_STAGE = DEF_QBITS_PER_STAGE
)
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [15:0]             in_raw_buttons,
  input  wire logic [7:0]              in_left_trigger_raw,
  input  wire logic [7:0]              in_right_trigger_raw,
  input  wire logic signed [RAW_W-1:0] in_left_x_raw,
  input  wire logic signed [RAW_W-1:0] in_left_y_raw,
  input  wire logic signed [RAW_W-1:0] in_right_x_raw,
  input  wire logic signed [RAW_W-1:0] in_right_y_raw,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [14:0]             cfg_wdata,
  output logic                         out_valid,
  output logic signed [POS_W-1:0]      out_left_x_pos,
  output logic signed [POS_W-1:0]      out_left_y_pos,
  output logic signed [POS_W-1:0]      out_right_x_pos,
  output logic signed [POS_W-1:0]      out_right_y_pos,
  output logic [3:0]                   out_low_direction_flags,
  output logic [3:0]                   out_high_direction_flags,
  output logic [15:0]                  out_button_states
);

  localparam int NSTG    = (QW + QBITS_PER_STAGE - 1) / QBITS_PER_STAGE;
  localparam int LATENCY = NSTG + 3;

  logic [14:0] ldz_r, ldz_nxt;
  logic [14:0] rdz_r, rdz_nxt;
  logic [6:0]  dth_r, dth_nxt;
  logic [7:0]  tth_r, tth_nxt;

  logic [LATENCY-1:0] vld_r, vld_nxt;
  logic               accept;

  side_t side_a_r, side_a_nxt;
  side_t side_r [NSTG+1];
  side_t side_b_nxt;

  lane_t lane_s [NSTG+1][4];

  logic [MAG_W-1:0] ldiv, rdiv;
  logic signed [RAW_W-1:0] raw [4];
  logic [MAG_W-1:0] lane_dz  [4];
  logic [MAG_W-1:0] lane_div [4];

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_comb begin
    ldz_nxt = ldz_r;
    rdz_nxt = rdz_r;
    dth_nxt = dth_r;
    tth_nxt = tth_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LEFT_DZ:  ldz_nxt = cfg_wdata;
        CFG_RIGHT_DZ: rdz_nxt = cfg_wdata;
        CFG_DIG_TH:   dth_nxt = cfg_wdata[6:0];
        CFG_TRIG_TH:  tth_nxt = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ldz_r <= LEFT_DZ_RST;
      rdz_r <= RIGHT_DZ_RST;
      dth_r <= DIG_TH_RST;
      tth_r <= TRIG_TH_RST;
      vld_r <= '0;
    end else begin
      ldz_r <= ldz_nxt;
      rdz_r <= rdz_nxt;
      dth_r <= dth_nxt;
      tth_r <= tth_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    vld_nxt = {vld_r[LATENCY-2:0], accept};
  end

  // side band: buttons and trigger compares
  always_comb begin
    side_a_nxt.buttons = in_raw_buttons;
    side_a_nxt.lt_hit  = (in_left_trigger_raw > tth_r);
    side_a_nxt.rt_hit  = (in_right_trigger_raw > tth_r);
    side_b_nxt         = side_a_r;
  end

  always_ff @(posedge clk) begin
    side_a_r  <= side_a_nxt;
    side_r[0] <= side_b_nxt;
  end

  assign ldiv = THUMB_MAX - ldz_r;
  assign rdiv = THUMB_MAX - rdz_r;

  always_comb begin
    raw[0]      = in_left_x_raw;
    raw[1]      = in_left_y_raw;
    raw[2]      = in_right_x_raw;
    raw[3]      = in_right_y_raw;
    lane_dz[0]  = ldz_r;
    lane_dz[1]  = ldz_r;
    lane_dz[2]  = rdz_r;
    lane_dz[3]  = rdz_r;
    lane_div[0] = ldiv;
    lane_div[1] = ldiv;
    lane_div[2] = rdiv;
    lane_div[3] = rdiv;
  end

  for (genvar i = 0; i < 4; i++) begin : g_front
    gprn_front u_front (
      .clk    (clk),
      .raw    (raw[i]),
      .dz     (lane_dz[i]),
      .lane_o (lane_s[0][i])
    );
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_div
    localparam int TB   = QW - 1 - s * QBITS_PER_STAGE;
    localparam int LEFT = QW - s * QBITS_PER_STAGE;
    localparam int NB   = (LEFT < QBITS_PER_STAGE) ? LEFT : QBITS_PER_STAGE;

    for (genvar i = 0; i < 4; i++) begin : g_lane
      gprn_div_stage #(
        .TOP_BIT (TB),
        .NBITS   (NB)
      ) u_div (
        .clk     (clk),
        .lane_i  (lane_s[s][i]),
        .divisor (lane_div[i]),
        .lane_o  (lane_s[s+1][i])
      );
    end

    always_ff @(posedge clk) begin
      side_r[s+1] <= side_r[s];
    end
  end

  gprn_output u_out (
    .clk         (clk),
    .lanes       (lane_s[NSTG]),
    .side        (side_r[NSTG]),
    .dig_th      (dth_r),
    .left_x_pos  (out_left_x_pos),
    .left_y_pos  (out_left_y_pos),
    .right_x_pos (out_right_x_pos),
    .right_y_pos (out_right_y_pos),
    .low_flags   (out_low_direction_flags),
    .high_flags  (out_high_direction_flags),
    .buttons     (out_button_states)
  );

  assign out_valid = vld_r[LATENCY-1];

endmodule

`default_nettype wire

// ===== design/gprn_front.sv =====
// ----------------------------------------------------------------------------
// Axis front end
// Clamp, magnitude, deadzone test, then numerator (|v|-dz)*127. Two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gprn_front
  import gprn_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic signed [RAW_W-1:0] raw,
  input  wire logic [MAG_W-1:0]        dz,
  output lane_t                        lane_o
);

  logic [RAW_W-1:0] mag_full;
  logic [MAG_W-1:0] mag;

  logic             neg_r,  neg_nxt;
  logic             zero_r, zero_nxt;
  logic [MAG_W-1:0] diff_r, diff_nxt;
  lane_t            lane_r, lane_nxt;

  always_comb begin
    mag_full = raw[RAW_W-1] ? (~raw + RAW_W'(1)) : raw;
    mag      = mag_full[RAW_W-1] ? THUMB_MAX : mag_full[MAG_W-1:0];
    neg_nxt  = raw[RAW_W-1];
    zero_nxt = (mag <= dz);
    diff_nxt = mag - dz;
  end

  always_comb begin
    lane_nxt.zero = zero_r;
    lane_nxt.neg  = neg_r;
    lane_nxt.rem  = {diff_r, {QW{1'b0}}} - {{QW{1'b0}}, diff_r};
    lane_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    diff_r <= diff_nxt;
    lane_r <= lane_nxt;
  end

  assign lane_o = lane_r;

endmodule

`default_nettype wire

// ===== design/gprn_div_stage.sv =====
// ----------------------------------------------------------------------------
// Divider stage
// Restoring division, NBITS quotient bits from TOP_BIT downwards, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gprn_div_stage
  import gprn_pkg::*;
#(
  parameter int TOP_BIT = QW - 1,
  parameter int NBITS   = DEF_QBITS_PER_STAGE
)
(
  input  wire logic             clk,
  input  wire lane_t            lane_i,
  input  wire logic [MAG_W-1:0] divisor,
  output lane_t                 lane_o
);

  lane_t            cur;
  logic [NUM_W-1:0] trial;
  lane_t            lane_r, lane_nxt;

  always_comb begin
    cur   = lane_i;
    trial = '0;
    for (int k = 0; k < NBITS; k++) begin
      trial = NUM_W'(divisor) << (TOP_BIT - k);
      if (cur.rem >= trial) begin
        cur.rem                = cur.rem - trial;
        cur.quo[TOP_BIT - k]   = 1'b1;
      end
    end
    lane_nxt = cur;
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_o = lane_r;

endmodule

`default_nettype wire

// ===== design/gprn_output.sv =====
// ----------------------------------------------------------------------------
// Output stage
// Sign and Y inversion, direction flags, D-pad override, button remap.
// ----------------------------------------------------------------------------
`default_nettype none

module gprn_output
  import gprn_pkg::*;
(
  input  wire logic                    clk,
  input  wire lane_t                   lanes [4],
  input  wire side_t                   side,
  input  wire logic [6:0]              dig_th,
  output logic signed [POS_W-1:0]      left_x_pos,
  output logic signed [POS_W-1:0]      left_y_pos,
  output logic signed [POS_W-1:0]      right_x_pos,
  output logic signed [POS_W-1:0]      right_y_pos,
  output logic [3:0]                   low_flags,
  output logic [3:0]                   high_flags,
  output logic [15:0]                  buttons
);

  logic [POS_W-1:0]   mag   [4];
  logic [POS_W-1:0]   pos   [4];
  logic               sgn;
  logic signed [POS_W:0] ps;
  logic signed [POS_W:0] ths;
  logic [3:0]         lo, hi;
  logic [15:0]        b;

  logic [POS_W-1:0]   pos_r [4];
  logic [POS_W-1:0]   pos_nxt [4];
  logic [3:0]         lo_r, lo_nxt;
  logic [3:0]         hi_r, hi_nxt;
  logic [15:0]        btn_r, btn_nxt;

  always_comb begin
    b   = side.buttons;
    ths = $signed({2'b00, dig_th});
    lo  = '0;
    hi  = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = lanes[i].zero ? '0 : {1'b0, lanes[i].quo};
      sgn    = lanes[i].neg ^ (i % 2 == 1);
      pos[i] = sgn ? (~mag[i] + POS_W'(1)) : mag[i];
      ps     = $signed({pos[i][POS_W-1], pos[i]});
      lo[i]  = (ps < -ths);
      hi[i]  = (ps > ths);
    end

    if (b[2]) begin
      pos[0] = POS_MIN; lo[0] = 1'b1; hi[0] = 1'b0;
    end else if (b[3]) begin
      pos[0] = POS_MAX; lo[0] = 1'b0; hi[0] = 1'b1;
    end
    if (b[0]) begin
      pos[1] = POS_MIN; lo[1] = 1'b1; hi[1] = 1'b0;
    end else if (b[1]) begin
      pos[1] = POS_MAX; lo[1] = 1'b0; hi[1] = 1'b1;
    end

    for (int i = 0; i < 4; i++) begin
      pos_nxt[i] = pos[i];
    end
    lo_nxt  = lo;
    hi_nxt  = hi;
    btn_nxt = {side.rt_hit, side.lt_hit, b[3:0], b[7:6], b[4], b[5], b[9:8], b[15:12]};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pos_r[i] <= pos_nxt[i];
    end
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    btn_r <= btn_nxt;
  end

  assign left_x_pos  = $signed(pos_r[0]);
  assign left_y_pos  = $signed(pos_r[1]);
  assign right_x_pos = $signed(pos_r[2]);
  assign right_y_pos = $signed(pos_r[3]);
  assign low_flags   = lo_r;
  assign high_flags  = hi_r;
  assign buttons     = btn_r;

endmodule

`default_nettype wire

// ===== design/gprn_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Latency, result pairing, flag exclusivity and mapping checks on the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gamepad_report_normalizer_top_macros.svh"

module gprn_checker #(
  parameter int LAT = 7
)
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [15:0]       in_raw_buttons,
  input wire logic              out_valid,
  input wire logic signed [7:0] out_left_x_pos,
  input wire logic [3:0]        out_low_direction_flags,
  input wire logic [3:0]        out_high_direction_flags,
  input wire logic [15:0]       out_button_states
);

  `GPRN_ASSERT_DLY(a_latency, clk, rst_n, start && !busy, LAT, out_valid, "missing result")
  `GPRN_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, $past(start && !busy, LAT), "spurious result")
  `GPRN_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid, (out_low_direction_flags & out_high_direction_flags) == 4'h0, "low and high flag both set")
  `GPRN_ASSERT_DLY(a_dpad_left, clk, rst_n, start && !busy && in_raw_buttons[2], LAT, out_left_x_pos == -8'sd128 && out_low_direction_flags[0] && !out_high_direction_flags[0], "dpad left not applied")
  `GPRN_ASSERT_IMP(a_dpad_map, clk, rst_n, out_valid, out_button_states[13:10] == $past(in_raw_buttons[3:0], LAT), "dpad buttons misrouted")

endmodule

bind gamepad_report_normalizer_top gprn_checker #(.LAT(LATENCY)) u_gprn_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .start                    (start),
  .busy                     (busy),
  .in_raw_buttons           (in_raw_buttons),
  .out_valid                (out_valid),
  .out_left_x_pos           (out_left_x_pos),
  .out_low_direction_flags  (out_low_direction_flags),
  .out_high_direction_flags (out_high_direction_flags),
  .out_button_states        (out_button_states)
);

`default_nettype wire
